@@ rtl/software_timer_table_unit_macros.svh @@
// Assertion macros for the software timer table unit.
`ifndef SOFTWARE_TIMER_TABLE_UNIT_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define STT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define STT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/stt_pkg.sv @@
// Package of codes and constants for the software timer table unit.
`timescale 1ns / 1ps
package stt_pkg;
  localparam int DEF_NUM_TIMERS = 16;
  localparam int ID_W = 4;
  localparam int MAX_SLOTS = 16;

  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_QUERY   = 3'd2;
  localparam logic [2:0] OP_STOP    = 3'd3;
  localparam logic [2:0] OP_DELETE  = 3'd4;
  localparam logic [2:0] OP_SERVICE = 3'd5;
  localparam logic [2:0] OP_DONE    = 3'd6;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_REFUSED = 3'd1;
  localparam logic [2:0] ST_NOSLOT  = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_PENDING = 3'd4;

  typedef struct packed {
    logic [2:0]  status;
    logic        result_flag;
    logic [3:0]  new_id;
    logic [31:0] remaining_ticks;
    logic        fired;
    logic [3:0]  fired_id;
    logic [31:0] wait_ticks;
  } result_t;
endpackage

@@ rtl/software_timer_table_unit.sv @@
// Top level of the software timer table unit: slot table, scan sequencer, output register.
`timescale 1ns / 1ps
`include "software_timer_table_unit_macros.svh"
// Usage:
//  Input words arrive on in_tvalid/in_tready/in_tdata; each word gives exactly one
//  result word on out_tvalid/out_tready/out_tdata.
//  in_tdata: operation[2:0], slot id[6:3], timeout[38:7], start_flags[41:39],
//  now_ticks[105:42], zero fill up to bit 111.
//  Start/query/stop/delete/done go from the accepted word to the finish state and
//  then to the output register. Create and service scan all used slots with one
//  shared 64-bit comparator and subtractor, one slot a cycle, before the finish state.
//  The block takes one word at a time; in_tready is low while a word is in work
//  and while the result register still holds a word not yet taken.
//  A stalled receiver holds the result in the output register; no word is lost.
//  Reset (rst_n low, synchronous) clears all slots, marks and the fired record;
//  no clearing pass is needed since every table lives in flip-flops.
module software_timer_table_unit #(
  parameter int NUM_TIMERS = stt_pkg::DEF_NUM_TIMERS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation, slot id, timeout, start_flags, now_ticks (low bit up)
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, result_flag, new_id, remaining_ticks, fired, fired_id, wait_ticks
  output logic [79:0]  out_tdata
);
  localparam int USED = (NUM_TIMERS < stt_pkg::MAX_SLOTS) ? NUM_TIMERS : stt_pkg::MAX_SLOTS;
  localparam int CW = $clog2(USED + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [CW-1:0] cnt_r;
  logic [2:0]  op_r;
  logic [3:0]  id_r;
  logic [31:0] to_r;
  logic [2:0]  fl_r;
  logic [63:0] now_r;
  logic        found_r;
  logic [3:0]  best_r;
  logic [63:0] best_exp_r;

  logic [USED-1:0] alloc_r, rep_r, exec_r, delp_r;
  logic [63:0] exp_r [USED];
  logic [31:0] per_r [USED];
  logic [3:0]  fslot_r;
  logic [63:0] fexp_r;

  stt_pkg::result_t res_r, res_nxt;
  logic out_valid_r;

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.wait_ticks, res_r.fired_id, res_r.fired,
                       res_r.remaining_ticks, res_r.new_id, res_r.result_flag,
                       res_r.status};

  wire accept = in_tvalid && in_tready;
  wire [$clog2(USED)-1:0] sidx = cnt_r[$clog2(USED)-1:0];
  wire [$clog2(USED)-1:0] iidx = id_r[$clog2(USED)-1:0];
  wire [$clog2(USED)-1:0] bidx = best_r[$clog2(USED)-1:0];
  wire [$clog2(USED)-1:0] fidx = fslot_r[$clog2(USED)-1:0];
  wire id_ok = ({28'd0, id_r} < USED) && alloc_r[iidx];
  wire fs_ok = ({28'd0, fslot_r} < USED);

  // shared comparator / subtractor: scan uses slot expiry, finish uses operands
  logic [63:0] cmp_a, cmp_b, diff;
  logic        a_lt_b;
  always_comb begin
    if (state_r == S_SCAN) begin
      cmp_a = exp_r[sidx];
      cmp_b = best_exp_r;
    end else if (op_r == stt_pkg::OP_SERVICE) begin
      cmp_a = now_r;
      cmp_b = best_exp_r;
    end else begin
      cmp_a = now_r;
      cmp_b = exp_r[iidx];
    end
    a_lt_b = cmp_a < cmp_b;
    diff = cmp_b - cmp_a;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) begin
        state_nxt = (in_tdata[2:0] == stt_pkg::OP_CREATE ||
                     in_tdata[2:0] == stt_pkg::OP_SERVICE) ? S_SCAN : S_FIN;
      end
      S_SCAN: if (cnt_r == CW'(USED - 1)) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // result of the finishing cycle
  always_comb begin
    res_nxt = '0;
    case (op_r)
      stt_pkg::OP_START, stt_pkg::OP_QUERY, stt_pkg::OP_STOP, stt_pkg::OP_DELETE: begin
        if (!id_ok) res_nxt.status = stt_pkg::ST_UNKNOWN;
        else if (delp_r[iidx]) res_nxt.status = stt_pkg::ST_PENDING;
        else if (op_r == stt_pkg::OP_START) begin
          if ((exec_r[iidx] && fl_r[1]) || (fl_r[2] && exp_r[iidx] != 64'd0))
            res_nxt.status = stt_pkg::ST_REFUSED;
          else res_nxt.result_flag = 1'b1;
        end else if (op_r == stt_pkg::OP_QUERY) begin
          res_nxt.result_flag = exp_r[iidx] != 64'd0;
          if (exp_r[iidx] != 64'd0 && a_lt_b)
            res_nxt.remaining_ticks = (diff[63:32] != 32'd0) ? '1 : diff[31:0];
        end else if (op_r == stt_pkg::OP_STOP) begin
          res_nxt.result_flag = !exec_r[iidx];
        end
      end
      stt_pkg::OP_CREATE: begin
        if (found_r) res_nxt.new_id = best_r;
        else res_nxt.status = stt_pkg::ST_NOSLOT;
      end
      stt_pkg::OP_SERVICE: begin
        if (fs_ok && exec_r[fidx]) res_nxt.status = stt_pkg::ST_REFUSED;
        else if (!found_r) res_nxt.wait_ticks = '1;
        else if (!a_lt_b) begin
          res_nxt.fired = 1'b1;
          res_nxt.fired_id = best_r;
        end else begin
          res_nxt.wait_ticks = (diff >= 64'hFFFF_FFFE) ? 32'hFFFF_FFFE : diff[31:0];
        end
      end
      stt_pkg::OP_DONE: begin
        if (!fs_ok || !exec_r[fidx]) res_nxt.status = stt_pkg::ST_REFUSED;
        else res_nxt.fired_id = fslot_r;
      end
      default: res_nxt.status = stt_pkg::ST_REFUSED;
    endcase
  end

  // control and table registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
      found_r <= 1'b0;
      alloc_r <= '0;
      rep_r <= '0;
      exec_r <= '0;
      delp_r <= '0;
      fslot_r <= '0;
      fexp_r <= '0;
      for (int i = 0; i < USED; i++) begin
        exp_r[i] <= '0;
        per_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (accept) begin
        op_r  <= in_tdata[2:0];
        id_r  <= in_tdata[6:3];
        to_r  <= in_tdata[38:7];
        fl_r  <= in_tdata[41:39];
        now_r <= in_tdata[105:42];
        cnt_r <= '0;
        found_r <= 1'b0;
        best_r <= '0;
        best_exp_r <= '0;
      end
      if (state_r == S_SCAN) begin
        cnt_r <= cnt_r + CW'(1);
        if (op_r == stt_pkg::OP_CREATE) begin
          if (!found_r && !alloc_r[sidx]) begin
            found_r <= 1'b1;
            best_r <= 4'(sidx);
          end
        end else if (alloc_r[sidx] && exp_r[sidx] != 64'd0 && (!found_r || a_lt_b)) begin
          found_r <= 1'b1;
          best_r <= 4'(sidx);
          best_exp_r <= exp_r[sidx];
        end
      end
      if (state_r == S_FIN) begin
        res_r <= res_nxt;
        out_valid_r <= 1'b1;
        case (op_r)
          stt_pkg::OP_START: if (res_nxt.result_flag) begin
            exp_r[iidx] <= now_r + {32'd0, to_r};
            rep_r[iidx] <= fl_r[0];
            per_r[iidx] <= to_r;
          end
          stt_pkg::OP_STOP, stt_pkg::OP_DELETE:
            if (res_nxt.status == stt_pkg::ST_OK) begin
              exp_r[iidx] <= '0;
              rep_r[iidx] <= 1'b0;
              if (op_r == stt_pkg::OP_DELETE) begin
                if (exec_r[iidx]) delp_r[iidx] <= 1'b1;
                else begin
                  alloc_r[iidx] <= 1'b0;
                  per_r[iidx] <= '0;
                end
              end
            end
          stt_pkg::OP_CREATE: if (found_r) begin
            alloc_r[bidx] <= 1'b1;
            exp_r[bidx] <= '0;
            per_r[bidx] <= '0;
            rep_r[bidx] <= 1'b0;
            exec_r[bidx] <= 1'b0;
            delp_r[bidx] <= 1'b0;
          end
          stt_pkg::OP_SERVICE: if (res_nxt.fired) begin
            fexp_r <= best_exp_r;
            fslot_r <= best_r;
            exec_r[bidx] <= 1'b1;
            exp_r[bidx] <= '0;
          end
          stt_pkg::OP_DONE: if (res_nxt.status == stt_pkg::ST_OK) begin
            exec_r[fidx] <= 1'b0;
            if (delp_r[fidx]) begin
              alloc_r[fidx] <= 1'b0;
              exp_r[fidx] <= '0;
              per_r[fidx] <= '0;
              rep_r[fidx] <= 1'b0;
              delp_r[fidx] <= 1'b0;
            end else if (rep_r[fidx] && exp_r[fidx] == 64'd0) begin
              exp_r[fidx] <= fexp_r + {32'd0, per_r[fidx]};
            end
          end
          default: ;
        endcase
      end
    end
  end

  `STT_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_r != S_IDLE, !in_tready,
                  "ready while a word is in work")
  `STT_ASSERT_NXT(a_fin_valid, clk, rst_n, state_r == S_FIN, out_valid_r,
                  "finish did not present a result")
  `STT_ASSERT_IMP(a_fired_exec, clk, rst_n, out_valid_r && res_r.fired,
                  exec_r[res_r.fired_id[$clog2(USED)-1:0]], "fired slot not executing")
endmodule

@@ verif/tb.sv @@
// Testbench for the software timer table unit: directed and random words checked against a predictor.
`timescale 1ns / 1ps
module tb;
  typedef struct {
    logic [2:0]  status;
    logic        result_flag;
    logic [3:0]  new_id;
    logic [31:0] remaining_ticks;
    logic        fired;
    logic [3:0]  fired_id;
    logic [31:0] wait_ticks;
  } timer_result_t;

  localparam int NSLOT = 16;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [79:0]  out_tdata;

  // predictor copy of the timer table
  logic        slot_used [NSLOT];
  logic [63:0] slot_expiry [NSLOT];
  logic [31:0] slot_period [NSLOT];
  logic        slot_repeat [NSLOT];
  logic        slot_exec [NSLOT];
  logic        slot_del [NSLOT];
  logic [3:0]  last_fired;
  logic [63:0] last_fired_expiry;

  timer_result_t pending_results[$];
  int  fail_count;
  bit  quiet;
  logic [63:0] now_base;

  software_timer_table_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

  function automatic void free_slot(int s);
    slot_used[s] = 1'b0;
    slot_expiry[s] = '0;
    slot_period[s] = '0;
    slot_repeat[s] = 1'b0;
    slot_exec[s] = 1'b0;
    slot_del[s] = 1'b0;
  endfunction

  function automatic logic [31:0] clip32(logic [63:0] v, logic [31:0] cap);
    return (v > {32'd0, cap}) ? cap : v[31:0];
  endfunction

  // next result of the table for one word; updates the predictor state
  function automatic timer_result_t table_step(logic [2:0] op, logic [3:0] id,
      logic [31:0] tmo, logic [2:0] flg, logic [63:0] now);
    timer_result_t r;
    bit found;
    int best;
    r = '{default: '0};
    found = 0;
    best = 0;
    if (op >= stt_pkg::OP_START && op <= stt_pkg::OP_DELETE) begin
      if (!slot_used[id]) r.status = stt_pkg::ST_UNKNOWN;
      else if (slot_del[id]) r.status = stt_pkg::ST_PENDING;
      else if (op == stt_pkg::OP_START) begin
        if ((slot_exec[id] && flg[1]) || (flg[2] && slot_expiry[id] != 0)) begin
          r.status = stt_pkg::ST_REFUSED;
        end else begin
          slot_expiry[id] = now + {32'd0, tmo};
          slot_repeat[id] = flg[0];
          slot_period[id] = tmo;
          r.result_flag = 1'b1;
        end
      end else if (op == stt_pkg::OP_QUERY) begin
        r.result_flag = slot_expiry[id] != 0;
        if (r.result_flag && slot_expiry[id] > now)
          r.remaining_ticks = clip32(slot_expiry[id] - now, 32'hFFFF_FFFF);
      end else if (op == stt_pkg::OP_STOP) begin
        slot_expiry[id] = '0;
        slot_repeat[id] = 1'b0;
        r.result_flag = !slot_exec[id];
      end else begin
        slot_expiry[id] = '0;
        slot_repeat[id] = 1'b0;
        if (slot_exec[id]) slot_del[id] = 1'b1;
        else free_slot(id);
      end
    end else if (op == stt_pkg::OP_CREATE) begin
      r.status = stt_pkg::ST_NOSLOT;
      for (int i = 0; i < NSLOT; i++) begin
        if (!slot_used[i] && r.status == stt_pkg::ST_NOSLOT) begin
          free_slot(i);
          slot_used[i] = 1'b1;
          r.new_id = i[3:0];
          r.status = stt_pkg::ST_OK;
        end
      end
    end else if (op == stt_pkg::OP_SERVICE) begin
      if (slot_exec[last_fired]) begin
        r.status = stt_pkg::ST_REFUSED;
      end else begin
        // earliest scheduled expiry, ties to the lowest slot
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_used[i] && slot_expiry[i] != 0 &&
              (!found || slot_expiry[i] < slot_expiry[best])) begin
            found = 1;
            best = i;
          end
        end
        if (!found) begin
          r.wait_ticks = 32'hFFFF_FFFF;
        end else if (slot_expiry[best] <= now) begin
          last_fired_expiry = slot_expiry[best];
          last_fired = best[3:0];
          slot_exec[best] = 1'b1;
          slot_expiry[best] = '0;
          r.fired = 1'b1;
          r.fired_id = best[3:0];
        end else begin
          r.wait_ticks = clip32(slot_expiry[best] - now, 32'hFFFF_FFFE);
        end
      end
    end else if (op == stt_pkg::OP_DONE) begin
      if (!slot_exec[last_fired]) begin
        r.status = stt_pkg::ST_REFUSED;
      end else begin
        slot_exec[last_fired] = 1'b0;
        if (slot_repeat[last_fired] && slot_expiry[last_fired] == 0)
          slot_expiry[last_fired] = last_fired_expiry + {32'd0, slot_period[last_fired]};
        if (slot_del[last_fired]) free_slot(last_fired);
        r.fired_id = last_fired;
      end
    end else begin
      r.status = stt_pkg::ST_REFUSED;
    end
    return r;
  endfunction

  // drive one word, wait for acceptance, then an optional gap
  task automatic send_word(logic [2:0] op, logic [3:0] id, logic [31:0] tmo,
      logic [2:0] flg, logic [63:0] now);
    int gap;
    pending_results.push_back(table_step(op, id, tmo, flg, now));
    in_tdata = {6'd0, now, flg, tmo, id, op};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // receiver stalls
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      int stall;
      @(negedge clk);
      stall = quiet ? 0 : $urandom_range(0, 6);
      out_tready = 1'b0;
      repeat (stall) @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      timer_result_t want, got;
      got.status = out_tdata[2:0];
      got.result_flag = out_tdata[3];
      got.new_id = out_tdata[7:4];
      got.remaining_ticks = out_tdata[39:8];
      got.fired = out_tdata[40];
      got.fired_id = out_tdata[44:41];
      got.wait_ticks = out_tdata[76:45];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          fail_count++;
        end
        if (got.result_flag != want.result_flag) begin
          $display("%0t: result_flag exp %0d got %0d", $time, want.result_flag,
                   got.result_flag);
          fail_count++;
        end
        if (got.new_id != want.new_id) begin
          $display("%0t: new_id exp %0d got %0d", $time, want.new_id, got.new_id);
          fail_count++;
        end
        if (got.remaining_ticks != want.remaining_ticks) begin
          $display("%0t: remaining_ticks exp %h got %h", $time, want.remaining_ticks,
                   got.remaining_ticks);
          fail_count++;
        end
        if (got.fired != want.fired) begin
          $display("%0t: fired exp %0d got %0d", $time, want.fired, got.fired);
          fail_count++;
        end
        if (got.fired_id != want.fired_id) begin
          $display("%0t: fired_id exp %0d got %0d", $time, want.fired_id, got.fired_id);
          fail_count++;
        end
        if (got.wait_ticks != want.wait_ticks) begin
          $display("%0t: wait_ticks exp %h got %h", $time, want.wait_ticks,
                   got.wait_ticks);
          fail_count++;
        end
      end
    end
  end

  // extremes, every operation and each corner case
  task automatic test_directed();
    for (int i = 0; i < NSLOT; i++) send_word(stt_pkg::OP_CREATE, 4'd0, '0, '0, '0);
    send_word(stt_pkg::OP_CREATE, 4'd0, '0, '0, '0);                 // table full
    send_word(stt_pkg::OP_START, 4'd0, 32'd10, 3'b001, 64'd100);
    send_word(stt_pkg::OP_QUERY, 4'd0, '0, '0, 64'd103);
    send_word(stt_pkg::OP_START, 4'd0, 32'd5, 3'b100, 64'd100);      // already scheduled
    send_word(stt_pkg::OP_SERVICE, 4'd0, '0, '0, 64'd105);
    send_word(stt_pkg::OP_SERVICE, 4'd0, '0, '0, 64'd110);           // fires slot 0
    send_word(stt_pkg::OP_SERVICE, 4'd0, '0, '0, 64'd111);           // callback outstanding
    send_word(stt_pkg::OP_START, 4'd0, 32'd3, 3'b010, 64'd111);      // refused while executing
    send_word(stt_pkg::OP_DELETE, 4'd0, '0, '0, 64'd111);            // deferred
    send_word(stt_pkg::OP_QUERY, 4'd0, '0, '0, 64'd111);             // pending delete
    send_word(stt_pkg::OP_DONE, 4'd0, '0, '0, 64'd112);
    send_word(stt_pkg::OP_QUERY, 4'd0, '0, '0, 64'd112);             // unknown now
    send_word(stt_pkg::OP_DONE, 4'd0, '0, '0, 64'd112);              // nothing outstanding
    send_word(OP_UNUSED, 4'hF, '1, 3'b111, '1);
    send_word(stt_pkg::OP_START, 4'd1, 32'd5, 3'b000, 64'hFFFF_FFFF_FFFF_FFFB); // wraps
    send_word(stt_pkg::OP_QUERY, 4'd1, '0, '0, '1);
    send_word(stt_pkg::OP_START, 4'd2, 32'hFFFF_FFFF, 3'b000, 64'd0);
    send_word(stt_pkg::OP_QUERY, 4'd2, '0, '0, 64'd0);
    send_word(stt_pkg::OP_SERVICE, 4'd0, '0, '0, 64'd0);             // long wait saturates
    send_word(stt_pkg::OP_STOP, 4'd2, '0, '0, 64'd1);
    send_word(stt_pkg::OP_SERVICE, 4'd0, '0, '0, 64'd1);             // none scheduled
    send_word(stt_pkg::OP_DELETE, 4'hF, '0, '0, 64'd1);
  endtask

  // random sequences: mostly a live timer workload on a slowly moving clock
  task automatic test_random(int count);
    logic [2:0]  op;
    logic [31:0] tmo;
    logic [63:0] now;
    int pick;
    for (int n = 0; n < count; n++) begin
      if (n % 300 == 0) quiet = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 10) op = stt_pkg::OP_CREATE;
      else if (pick < 35) op = stt_pkg::OP_START;
      else if (pick < 45) op = stt_pkg::OP_QUERY;
      else if (pick < 52) op = stt_pkg::OP_STOP;
      else if (pick < 58) op = stt_pkg::OP_DELETE;
      else if (pick < 83) op = stt_pkg::OP_SERVICE;
      else if (pick < 97) op = stt_pkg::OP_DONE;
      else op = OP_UNUSED;
      pick = $urandom_range(0, 19);
      if (pick == 0) tmo = $urandom;
      else if (pick == 1) tmo = 32'hFFFF_FFFF - $urandom_range(0, 3);
      else tmo = $urandom_range(0, 40);
      pick = $urandom_range(0, 199);
      if (pick == 0) now_base = {$urandom, $urandom};
      else if (pick == 1) now_base = 64'hFFFF_FFFF_FFFF_FFC0;
      else now_base = now_base + $urandom_range(0, 6);
      now = now_base;
      send_word(op, 4'($urandom_range(0, 15)), tmo, 3'($urandom_range(0, 7)), now);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    fail_count = 0;
    quiet = 0;
    now_base = 64'd200;
    for (int i = 0; i < NSLOT; i++) free_slot(i);
    last_fired = '0;
    last_fired_expiry = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(1800);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
